/* rtl/core/fixed_point_affine_vertex_transform_top_defines.svh */
// Assertion helpers for the affine vertex transform.
`ifndef FIXED_POINT_AFFINE_VERTEX_TRANSFORM_TOP_DEFINES_SVH
`define FIXED_POINT_AFFINE_VERTEX_TRANSFORM_TOP_DEFINES_SVH

// Consequent checked in the next cycle.
`define AVT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Consequent checked a fixed number of cycles later.
`define AVT_ASSERT_LAT(label, ante, n, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##n (cons)) else $error(msg);

`endif

/* rtl/core/avt_pkg.sv */
`timescale 1ns / 1ps

package avt_pkg;

    localparam int unsigned COORD_W  = 32;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned SHIFT_W  = 4;
    localparam int unsigned CFG_W    = 64;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned PROD_W   = COORD_W + WORD_W;   // 48
    localparam int unsigned DOT_W    = PROD_W + 1;         // 49
    localparam int unsigned SUM_W    = 65;
    localparam int unsigned FRAC_SH  = 15;
    localparam int unsigned Q_FRAC   = 16;
    localparam int unsigned PIPE_LAT = 4;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(16'h8000 / 2);

    typedef enum logic [IDX_W-1:0] {
        REG_ROW_X       = 3'd0,
        REG_ROW_Y       = 3'd1,
        REG_ROW_Z       = 3'd2,
        REG_ROT_SHIFT   = 3'd3,
        REG_TRANS_SHIFT = 3'd4
    } t_reg_idx;

    // r0 in the lowest bits, translation in the highest
    typedef struct packed {
        logic signed [WORD_W-1:0] t;
        logic signed [WORD_W-1:0] r2;
        logic signed [WORD_W-1:0] r1;
        logic signed [WORD_W-1:0] r0;
    } t_row;

    typedef struct packed {
        t_row               row_x;
        t_row               row_y;
        t_row               row_z;
        logic [SHIFT_W-1:0] rot_shift;
        logic [SHIFT_W-1:0] trans_shift;
    } t_cfg;

endpackage

/* rtl/core/avt_cfg_regs.sv */
`timescale 1ns / 1ps

module avt_cfg_regs
    import avt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_ROW_X:       n_cfg.row_x       = t_row'(i_cfg_data);
                REG_ROW_Y:       n_cfg.row_y       = t_row'(i_cfg_data);
                REG_ROW_Z:       n_cfg.row_z       = t_row'(i_cfg_data);
                REG_ROT_SHIFT:   n_cfg.rot_shift   = i_cfg_data[SHIFT_W-1:0];
                REG_TRANS_SHIFT: n_cfg.trans_shift = i_cfg_data[SHIFT_W-1:0];
                // drop writes to unmapped indices
                default:         n_cfg             = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/avt_row_unit.sv */
`timescale 1ns / 1ps

`include "fixed_point_affine_vertex_transform_top_defines.svh"

module avt_row_unit
    import avt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic signed [COORD_W-1:0] i_px,
    input  logic signed [COORD_W-1:0] i_py,
    input  logic signed [COORD_W-1:0] i_pz,
    input  t_row                      i_row,
    input  logic        [SHIFT_W-1:0] i_rot_shift,
    input  logic        [SHIFT_W-1:0] i_trans_shift,
    output logic signed [COORD_W-1:0] o_coord
);

    localparam int unsigned Q_W = SUM_W - FRAC_SH;

    logic signed [PROD_W-1:0]  r_p0, r_p1, r_p2;
    logic signed [PROD_W-1:0]  n_p0, n_p1, n_p2;
    logic signed [DOT_W-1:0]   r_dot;
    logic signed [DOT_W-1:0]   n_dot;
    logic signed [COORD_W-1:0] r_coord;
    logic signed [COORD_W-1:0] n_coord;

    logic signed [SUM_W-1:0]   scaled_dot;
    logic signed [SUM_W-1:0]   scaled_trn;
    logic signed [SUM_W-1:0]   sum;
    logic        [SHIFT_W:0]   trn_amt;
    logic signed [Q_W-1:0]     quot;

    // stage 1: products
    assign n_p0 = PROD_W'(i_px) * PROD_W'($signed(i_row.r0));
    assign n_p1 = PROD_W'(i_py) * PROD_W'($signed(i_row.r1));
    assign n_p2 = PROD_W'(i_pz) * PROD_W'($signed(i_row.r2));

    // stage 2: dot product
    assign n_dot = DOT_W'(r_p0) + DOT_W'(r_p1) + DOT_W'(r_p2);

    // stage 3: scale, add translation, round half up, saturate
    assign trn_amt    = {1'b0, i_trans_shift} + (SHIFT_W + 1)'(Q_FRAC);
    assign scaled_dot = SUM_W'(r_dot) <<< i_rot_shift;
    assign scaled_trn = SUM_W'($signed(i_row.t)) <<< trn_amt;
    assign sum        = scaled_dot + scaled_trn + ROUND_HALF;
    assign quot       = sum[SUM_W-1:FRAC_SH];

    always_comb begin
        if (quot[Q_W-1:COORD_W-1] == '0 || quot[Q_W-1:COORD_W-1] == '1) begin
            n_coord = quot[COORD_W-1:0];
        end else if (quot[Q_W-1]) begin
            n_coord = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            n_coord = {1'b0, {(COORD_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0    <= n_p0;
        r_p1    <= n_p1;
        r_p2    <= n_p2;
        r_dot   <= n_dot;
        r_coord <= n_coord;
    end

    assign o_coord = r_coord;

    `AVT_ASSERT_NEXT(a_sign_pos, !sum[SUM_W-1], !r_coord[COORD_W-1], "non-negative sum gave negative coord")
    `AVT_ASSERT_NEXT(a_sign_neg, sum[SUM_W-1], r_coord[COORD_W-1], "negative sum gave non-negative coord")

endmodule

/* rtl/core/fixed_point_affine_vertex_transform_top.sv */
`timescale 1ns / 1ps
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+------------------------------------
// vertex in | in        | start, busy            | i_pos_x, i_pos_y, i_pos_z, i_last_vertex
// result    | out       | o_valid (one cycle)    | o_out_x, o_out_y, o_out_z, o_out_last
// config    | in        | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// One vertex per clock; busy stays low. The input register loads at the accepting edge.
// The product, dot-sum and round/saturate stages follow it in that order, and the
// round/saturate register drives the result ports.
// Reset (synchronous, active low) clears the valid pipeline and all matrix registers.
// The receiver cannot stall: every result word is shown for exactly one cycle.

`include "fixed_point_affine_vertex_transform_top_defines.svh"

module fixed_point_affine_vertex_transform_top
    import avt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] i_pos_x,
    input  logic signed [COORD_W-1:0] i_pos_y,
    input  logic signed [COORD_W-1:0] i_pos_z,
    input  logic                      i_last_vertex,
    output logic                      o_valid,
    output logic signed [COORD_W-1:0] o_out_x,
    output logic signed [COORD_W-1:0] o_out_y,
    output logic signed [COORD_W-1:0] o_out_z,
    output logic                      o_out_last,
    input  logic                      i_cfg_we,
    input  logic        [IDX_W-1:0]   i_cfg_idx,
    input  logic        [CFG_W-1:0]   i_cfg_data
);

    t_cfg cfg;

    logic signed [COORD_W-1:0] r_px, r_py, r_pz;
    logic [PIPE_LAT-1:0]       r_vld;
    logic [PIPE_LAT-1:0]       n_vld;
    logic [PIPE_LAT-1:0]       r_last;
    logic [PIPE_LAT-1:0]       n_last;

    assign busy   = 1'b0;
    assign n_vld  = {r_vld[PIPE_LAT-2:0], start};
    assign n_last = {r_last[PIPE_LAT-2:0], i_last_vertex};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        r_last <= n_last;
        if (start) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
            r_pz <= i_pos_z;
        end
    end

    avt_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    avt_row_unit u_row_x (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_px          (r_px),
        .i_py          (r_py),
        .i_pz          (r_pz),
        .i_row         (cfg.row_x),
        .i_rot_shift   (cfg.rot_shift),
        .i_trans_shift (cfg.trans_shift),
        .o_coord       (o_out_x)
    );

    avt_row_unit u_row_y (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_px          (r_px),
        .i_py          (r_py),
        .i_pz          (r_pz),
        .i_row         (cfg.row_y),
        .i_rot_shift   (cfg.rot_shift),
        .i_trans_shift (cfg.trans_shift),
        .o_coord       (o_out_y)
    );

    avt_row_unit u_row_z (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_px          (r_px),
        .i_py          (r_py),
        .i_pz          (r_pz),
        .i_row         (cfg.row_z),
        .i_rot_shift   (cfg.rot_shift),
        .i_trans_shift (cfg.trans_shift),
        .o_coord       (o_out_z)
    );

    assign o_valid    = r_vld[PIPE_LAT-1];
    assign o_out_last = r_last[PIPE_LAT-1];

    `AVT_ASSERT_LAT(a_result_follows, start && !busy, 4, o_valid, "accepted word gave no result")
    `AVT_ASSERT_LAT(a_no_phantom, !start, 4, !o_valid, "result without accepted word")
    `AVT_ASSERT_LAT(a_last_kept, start && i_last_vertex, 4, o_out_last, "last flag lost")

endmodule

/* bench/avt_checker.sv */
`timescale 1ns / 1ps

module avt_checker
    import avt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_busy,
    input  logic signed [COORD_W-1:0] i_pos_x,
    input  logic signed [COORD_W-1:0] i_pos_y,
    input  logic signed [COORD_W-1:0] i_pos_z,
    input  logic                      i_last_vertex,
    input  logic                      i_valid,
    input  logic signed [COORD_W-1:0] i_out_x,
    input  logic signed [COORD_W-1:0] i_out_y,
    input  logic signed [COORD_W-1:0] i_out_z,
    input  logic                      i_out_last,
    input  logic                      i_cfg_we,
    input  logic        [IDX_W-1:0]   i_cfg_idx,
    input  logic        [CFG_W-1:0]   i_cfg_data,
    output int                        o_errors,
    output int                        o_pending
);

    localparam longint HALF_LSB  = longint'(1) <<< (FRAC_SH - 1);
    localparam longint COORD_MAX = (longint'(1) <<< (COORD_W - 1)) - 1;
    localparam longint COORD_MIN = -(longint'(1) <<< (COORD_W - 1));
    localparam int     MAX_SHOWN = 50;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      last;
    } t_vertex;

    t_cfg    matrix;
    t_vertex vertex_q[$];
    int      mismatches = 0;
    int      words_seen = 0;

    assign o_errors = mismatches;

    // One output coordinate: dot product, scaled, translation added, rounded half up, saturated.
    function automatic logic signed [COORD_W-1:0] transform_row(
        input t_row                      row,
        input logic        [SHIFT_W-1:0] rsh,
        input logic        [SHIFT_W-1:0] tsh,
        input logic signed [COORD_W-1:0] px,
        input logic signed [COORD_W-1:0] py,
        input logic signed [COORD_W-1:0] pz
    );
        longint dot;
        longint acc;
        dot = longint'(px) * longint'($signed(row.r0))
            + longint'(py) * longint'($signed(row.r1))
            + longint'(pz) * longint'($signed(row.r2));
        acc = (dot <<< rsh) + (longint'($signed(row.t)) <<< (tsh + Q_FRAC)) + HALF_LSB;
        acc = acc >>> FRAC_SH;
        if (acc > COORD_MAX)
            acc = COORD_MAX;
        else if (acc < COORD_MIN)
            acc = COORD_MIN;
        return COORD_W'(acc);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_SHOWN)
            $display("[%0t] word %0d: %s", $realtime, words_seen, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input longint got, input longint want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    always @(posedge i_clk) begin
        t_vertex want;
        if (!i_rst_n) begin
            matrix = '0;
            vertex_q.delete();
        end else begin
            if (i_valid) begin
                if (vertex_q.size() == 0) begin
                    report_mismatch("result word with nothing outstanding");
                end else begin
                    want = vertex_q.pop_front();
                    compare_field("out_x", i_out_x, want.x);
                    compare_field("out_y", i_out_y, want.y);
                    compare_field("out_z", i_out_z, want.z);
                    compare_field("out_last", i_out_last, want.last);
                end
                words_seen++;
            end
            if (i_start && !i_busy) begin
                want.x    = transform_row(matrix.row_x, matrix.rot_shift, matrix.trans_shift,
                                          i_pos_x, i_pos_y, i_pos_z);
                want.y    = transform_row(matrix.row_y, matrix.rot_shift, matrix.trans_shift,
                                          i_pos_x, i_pos_y, i_pos_z);
                want.z    = transform_row(matrix.row_z, matrix.rot_shift, matrix.trans_shift,
                                          i_pos_x, i_pos_y, i_pos_z);
                want.last = i_last_vertex;
                vertex_q.push_back(want);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ROW_X:       matrix.row_x       = i_cfg_data;
                    REG_ROW_Y:       matrix.row_y       = i_cfg_data;
                    REG_ROW_Z:       matrix.row_z       = i_cfg_data;
                    REG_ROT_SHIFT:   matrix.rot_shift   = i_cfg_data[SHIFT_W-1:0];
                    REG_TRANS_SHIFT: matrix.trans_shift = i_cfg_data[SHIFT_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending = vertex_q.size();
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import avt_pkg::*;

    localparam int unsigned ITEMS        = 1850;
    localparam int unsigned PHASES       = 12;
    localparam int unsigned IDLE_MAX     = 15;
    localparam int unsigned DRAIN_CYCLES = PIPE_LAT + 4;
    localparam int unsigned RESET_CYCLES = 7;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic signed [COORD_W-1:0] i_pos_x;
    logic signed [COORD_W-1:0] i_pos_y;
    logic signed [COORD_W-1:0] i_pos_z;
    logic                      i_last_vertex;
    logic                      o_valid;
    logic signed [COORD_W-1:0] o_out_x;
    logic signed [COORD_W-1:0] o_out_y;
    logic signed [COORD_W-1:0] o_out_z;
    logic                      o_out_last;
    logic                      i_cfg_we;
    logic        [IDX_W-1:0]   i_cfg_idx;
    logic        [CFG_W-1:0]   i_cfg_data;
    int                        errors;
    int                        pending;

    fixed_point_affine_vertex_transform_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_last_vertex (i_last_vertex),
        .o_valid       (o_valid),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z),
        .o_out_last    (o_out_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    avt_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_last_vertex (i_last_vertex),
        .i_valid       (o_valid),
        .i_out_x       (o_out_x),
        .i_out_y       (o_out_y),
        .i_out_z       (o_out_z),
        .i_out_last    (o_out_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(5_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'h0001;
            5: return 16'h4000;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_row();
        if ($urandom_range(0, 3) == 0)
            return {$urandom, $urandom};
        return {pick_word(), pick_word(), pick_word(), pick_word()};
    endfunction

    function automatic logic [SHIFT_W-1:0] pick_shift();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return SHIFT_W'($urandom_range(0, 15));
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord();
        logic signed [19:0] near;
        near = 20'($urandom);
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4, 5, 6: return COORD_W'(near);
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic send_vertex(
        input logic [COORD_W-1:0] px,
        input logic [COORD_W-1:0] py,
        input logic [COORD_W-1:0] pz,
        input logic               last
    );
        @(negedge i_clk);
        start         <= 1'b1;
        i_pos_x       <= px;
        i_pos_y       <= py;
        i_pos_z       <= pz;
        i_last_vertex <= last;
        // hold the word until it is taken
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_for(input int unsigned cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    // Stop sending and wait until every result word is back.
    task automatic drain();
        idle_for(1);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_setup();
        logic [CFG_W-1:0] junk;
        write_reg(REG_ROW_X, pick_row());
        write_reg(REG_ROW_Y, pick_row());
        write_reg(REG_ROW_Z, pick_row());
        junk = {$urandom, $urandom};
        write_reg(REG_ROT_SHIFT, {junk[CFG_W-1:SHIFT_W], pick_shift()});
        junk = {$urandom, $urandom};
        write_reg(REG_TRANS_SHIFT, {junk[CFG_W-1:SHIFT_W], pick_shift()});
        // an unmapped index must leave the matrix alone
        if ($urandom_range(0, 1) == 0)
            write_reg(IDX_W'(REG_TRANS_SHIFT) + IDX_W'($urandom_range(1, 3)), {$urandom, $urandom});
    endtask

    initial begin
        bit idling;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_pos_x       = '0;
        i_pos_y       = '0;
        i_pos_z       = '0;
        i_last_vertex = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset matrix: everything maps to zero.
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        drain();

        // Identity at rot_shift 1 with translations 3, -3 and 0x7FFF; upper data bits must be dropped.
        write_reg(REG_ROW_X, {16'h0003, 16'h0000, 16'h0000, 16'h4000});
        write_reg(REG_ROW_Y, {16'hFFFD, 16'h0000, 16'h4000, 16'h0000});
        write_reg(REG_ROW_Z, {16'h7FFF, 16'h4000, 16'h0000, 16'h0000});
        write_reg(REG_ROT_SHIFT, 64'hFFFF_FFFF_FFFF_FFF1);
        write_reg(REG_TRANS_SHIFT, 64'hABCD_0000_0000_0000);
        write_reg(IDX_W'(REG_TRANS_SHIFT) + 1'b1, '1);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1'b1);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
        send_vertex($urandom, $urandom, $urandom, 1'b0);
        drain();

        // Largest scales: drive both saturation bounds.
        write_reg(REG_ROW_X, {16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF});
        write_reg(REG_ROW_Y, {16'h0000, 16'h8000, 16'h8000, 16'h8000});
        write_reg(REG_ROW_Z, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
        write_reg(REG_ROT_SHIFT, 64'h0000_0000_0000_000F);
        write_reg(REG_TRANS_SHIFT, 64'h0000_0000_0000_000F);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_vertex(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        drain();

        // Half-way cases: ties go toward plus infinity.
        write_reg(REG_ROW_X, {16'h0000, 16'h0000, 16'h0000, 16'h0001});
        write_reg(REG_ROW_Y, {16'h0000, 16'h0000, 16'h0000, 16'hFFFF});
        write_reg(REG_ROW_Z, {16'h8000, 16'h0000, 16'h0000, 16'h0000});
        write_reg(REG_ROT_SHIFT, 64'h0);
        write_reg(REG_TRANS_SHIFT, 64'h0);
        send_vertex(32'h0000_4000, 32'h0, 32'h0, 1'b0);
        send_vertex(32'hFFFF_C000, 32'h0, 32'h0, 1'b1);
        send_vertex(32'h0000_3FFF, 32'h0, 32'h0, 1'b0);
        send_vertex(32'h0000_BFFF, 32'h0, 32'h0, 1'b1);
        send_vertex(32'hFFFF_BFFF, 32'h0, 32'h0, 1'b0);
        drain();

        // Translation alone at its largest scale.
        write_reg(REG_ROW_X, {16'h7FFF, 16'h0000, 16'h0000, 16'h0000});
        write_reg(REG_ROW_Y, {16'h8000, 16'h0000, 16'h0000, 16'h0000});
        write_reg(REG_ROW_Z, {16'hFFFF, 16'h0000, 16'h0000, 16'h0000});
        write_reg(REG_TRANS_SHIFT, 64'hF);
        send_vertex(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 1'b1);
        send_vertex(32'hF0F0_F0F0, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
        drain();

        for (int unsigned p = 0; p < PHASES; p++) begin
            random_setup();
            // no idling in the closing phase
            idling = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (int unsigned n = 0; n < ITEMS / PHASES; n++) begin
                if (idling && $urandom_range(0, 3) == 0)
                    idle_for($urandom_range(1, IDLE_MAX));
                send_vertex(pick_coord(), pick_coord(), pick_coord(), 1'($urandom));
            end
            drain();
        end

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* fixed_point_affine_vertex_transform_top.f */
+incdir+rtl/core
rtl/core/avt_pkg.sv
rtl/core/avt_cfg_regs.sv
rtl/core/avt_row_unit.sv
rtl/core/fixed_point_affine_vertex_transform_top.sv
bench/avt_checker.sv
bench/testbench.sv
